@@ src/crft_pkg.sv @@
package crft_pkg;

  // Default build-time sizes of the table
  localparam int unsigned DEF_POOL_DEPTH    = 32;
  localparam int unsigned DEF_CHANNEL_LIMIT = 512;

  // Fixed field widths of the request and response items
  localparam int unsigned ID_W     = 16;
  localparam int unsigned CH_W     = 10;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned OCC_W    = 6;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEL = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_GET = 2'd2;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // One stored fixture
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [CH_W-1:0] ch_start;
    logic [CH_W-1:0] ch_total;
    logic [CH_W-1:0] ch_end;
  } crft_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the accepted request
    logic scan_start;  // rewind the walk pointer to the first entry
    logic shift_start; // point the walk just past the matching entry
    logic run;         // issue table reads while entries remain
    logic shift_mode;  // reads feed the gap-closing write, not the compare
    logic commit;      // decide, update the table and load the response
  } crft_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;       // reads still outstanding
    logic found;      // identifier matched during the scan
    logic is_delete;  // captured request is a delete
    logic out_free;   // response register can take a new response
  } crft_stat_t;

endpackage

@@ src/channel_range_fixture_table.sv @@
// Channel   Direction  Protocol  Carries
// in_       slave      stream    request: action, fixture id, channel span
// out_      master     stream    response: status, index, entry fields, occupancy
//
// With n entries stored, every request walks all n of them, one entry a cycle
// through the single read port of the table memory, before it answers. A delete
// that hits position p then walks the entries behind it again, moving each one
// down to close the gap; none if the entry was the last. in_tready rises together
// with out_tvalid.
// Reset clears the entry count, the walk state and the response valid flag; no clearing pass.
// A stalled response holds in its register; the next request is still taken and
// waits at the end of its walk until that register frees.
module channel_range_fixture_table #(
  parameter int unsigned POOL_DEPTH    = crft_pkg::DEF_POOL_DEPTH,
  parameter int unsigned CHANNEL_LIMIT = crft_pkg::DEF_CHANNEL_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // fixture_id[15:0], start_channel[25:16], channel_total[35:26], end_channel[45:36]
  input  logic [47:0] in_tdata,
  // action[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // entry_index[4:0], entry_start[14:5], entry_channels[24:15], entry_end[34:25],
  // occupancy[40:35]
  output logic [47:0] out_tdata,
  // status[2:0]
  output logic [2:0]  out_tuser
);
  import crft_pkg::*;

  crft_cmd_t  cmd;
  crft_stat_t st;

  logic [STATUS_W-1:0] rsp_status;
  logic [INDEX_W-1:0]  rsp_index;
  logic [CH_W-1:0]     rsp_start;
  logic [CH_W-1:0]     rsp_channels;
  logic [CH_W-1:0]     rsp_end;
  logic [OCC_W-1:0]    rsp_occupancy;

  // Sequence each request: capture, scan, optional shift, answer
  crft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .st        (st)
  );

  // Table memory, scan compare, decision and response register
  crft_datapath #(
    .POOL_DEPTH    (POOL_DEPTH),
    .CHANNEL_LIMIT (CHANNEL_LIMIT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .req_action    (in_tuser),
    .req_id        (in_tdata[15:0]),
    .req_start     (in_tdata[25:16]),
    .req_total     (in_tdata[35:26]),
    .req_end       (in_tdata[45:36]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .rsp_status    (rsp_status),
    .rsp_index     (rsp_index),
    .rsp_start     (rsp_start),
    .rsp_channels  (rsp_channels),
    .rsp_end       (rsp_end),
    .rsp_occupancy (rsp_occupancy)
  );

  // Pack the response, padding to whole bytes
  assign out_tdata = {7'b0, rsp_occupancy, rsp_end, rsp_channels, rsp_start, rsp_index};
  assign out_tuser = rsp_status;

  // Table walk must be finished whenever a new request may be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !st.busy)
    else $error("table walk still active while accepting a request");

  // Drop out of idle straight after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while the previous one is in progress");

  // Never overwrite a response that has not been taken
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> st.out_free)
    else $error("response committed over a stalled response");

  // Reported occupancy stays within the table depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[40:35] <= POOL_DEPTH))
    else $error("occupancy above table depth");

endmodule

@@ src/crft_ctrl.sv @@
module crft_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output crft_pkg::crft_cmd_t cmd,
  input  crft_pkg::crft_stat_t st
);
  import crft_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } crft_state_t;

  crft_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.run = 1'b1;
        if (!st.busy) begin
          if (st.is_delete && st.found) begin
            cmd.shift_start = 1'b1;
            state_nxt       = S_SHIFT;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        cmd.run        = 1'b1;
        cmd.shift_mode = 1'b1;
        if (!st.busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the response register is free
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/crft_datapath.sv @@
module crft_datapath #(
  parameter int unsigned POOL_DEPTH    = crft_pkg::DEF_POOL_DEPTH,
  parameter int unsigned CHANNEL_LIMIT = crft_pkg::DEF_CHANNEL_LIMIT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crft_pkg::crft_cmd_t           cmd,
  output crft_pkg::crft_stat_t          st,
  input  logic [crft_pkg::ACTION_W-1:0] req_action,
  input  logic [crft_pkg::ID_W-1:0]     req_id,
  input  logic [crft_pkg::CH_W-1:0]     req_start,
  input  logic [crft_pkg::CH_W-1:0]     req_total,
  input  logic [crft_pkg::CH_W-1:0]     req_end,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [crft_pkg::STATUS_W-1:0] rsp_status,
  output logic [crft_pkg::INDEX_W-1:0]  rsp_index,
  output logic [crft_pkg::CH_W-1:0]     rsp_start,
  output logic [crft_pkg::CH_W-1:0]     rsp_channels,
  output logic [crft_pkg::CH_W-1:0]     rsp_end,
  output logic [crft_pkg::OCC_W-1:0]    rsp_occupancy
);
  import crft_pkg::*;

  localparam int unsigned IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);

  // Table memory: one write and one registered read a cycle
  crft_entry_t slot_mem [POOL_DEPTH];
  crft_entry_t rd_q_r;

  // Captured request
  logic [ACTION_W-1:0] act_r;
  crft_entry_t         req_r;

  // Walk control
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] sc_r, sc_nxt;
  logic             dv_r;
  logic [IDX_W-1:0] tag_r;
  logic             issue;

  // Scan findings
  logic             found_r, found_nxt;
  logic             clash_r, clash_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  crft_entry_t      hit_r, hit_nxt;
  logic             id_match, span_clash;

  // Decision
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_idx;
  crft_entry_t         res_entry;
  logic                add_ok, del_ok;
  logic [CNT_W-1:0]    cnt_after;
  logic [CNT_W+OCC_W-1:0]   occ_ext;
  logic [IDX_W+INDEX_W-1:0] idx_ext;

  // Memory write port
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  crft_entry_t      mem_wd;

  // Response register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] o_status_r;
  logic [INDEX_W-1:0]  o_index_r;
  crft_entry_t         o_entry_r;
  logic [OCC_W-1:0]    o_occ_r;

  assign issue = cmd.run && (sc_r < cnt_r);

  assign st.busy      = issue || dv_r;
  assign st.found     = found_r;
  assign st.is_delete = (act_r == ACT_DEL);
  assign st.out_free  = !out_valid_r || out_tready;

  // Compare the entry read back last cycle
  assign id_match   = (rd_q_r.id == req_r.id);
  assign span_clash = (req_r.ch_start <= rd_q_r.ch_end) &&
                      (({1'b0, rd_q_r.ch_start} + 11'd1) <=
                       ({1'b0, req_r.ch_start} + {1'b0, req_r.ch_total}));

  always_comb begin
    sc_nxt    = sc_r;
    found_nxt = found_r;
    clash_nxt = clash_r;
    pos_nxt   = pos_r;
    hit_nxt   = hit_r;
    if (cmd.scan_start) begin
      sc_nxt    = '0;
      found_nxt = 1'b0;
      clash_nxt = 1'b0;
    end else if (cmd.shift_start) begin
      sc_nxt = CNT_W'(pos_r) + CNT_W'(1);
    end else if (issue) begin
      sc_nxt = sc_r + CNT_W'(1);
    end
    if (dv_r && !cmd.shift_mode) begin
      if (id_match && !found_r) begin
        found_nxt = 1'b1;
        pos_nxt   = tag_r;
        hit_nxt   = rd_q_r;
      end
      if (span_clash) begin
        clash_nxt = 1'b1;
      end
    end
  end

  // Outcome of the request once the scan is complete
  always_comb begin
    res_status = ST_INVALID;
    res_idx    = '0;
    res_entry  = '0;
    add_ok     = 1'b0;
    del_ok     = 1'b0;
    case (act_r)
      ACT_ADD: begin
        if (found_r) begin
          res_status = ST_DUPLICATE;
        end else if (req_r.ch_end > CH_W'(CHANNEL_LIMIT)) begin
          res_status = ST_INVALID;
        end else if (clash_r) begin
          res_status = ST_INVALID;
        end else if (cnt_r >= CNT_W'(POOL_DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_OK;
          res_idx    = cnt_r[IDX_W-1:0];
          add_ok     = 1'b1;
        end
      end
      ACT_DEL: begin
        if (found_r) begin
          res_status = ST_OK;
          res_idx    = pos_r;
          del_ok     = 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      ACT_GET: begin
        if (found_r) begin
          res_status = ST_OK;
          res_idx    = pos_r;
          res_entry  = hit_r;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
  end

  always_comb begin
    if (add_ok) begin
      cnt_after = cnt_r + CNT_W'(1);
    end else if (del_ok) begin
      cnt_after = cnt_r - CNT_W'(1);
    end else begin
      cnt_after = cnt_r;
    end
    cnt_nxt = cmd.commit ? cnt_after : cnt_r;
    occ_ext = {{OCC_W{1'b0}}, cnt_after};
    idx_ext = {{INDEX_W{1'b0}}, res_idx};
  end

  // Write port: append on add, close the gap during a delete
  always_comb begin
    if (cmd.shift_mode) begin
      mem_we = dv_r;
      mem_wa = tag_r - IDX_W'(1);
      mem_wd = rd_q_r;
    end else begin
      mem_we = cmd.commit && add_ok;
      mem_wa = cnt_r[IDX_W-1:0];
      mem_wd = req_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    rd_q_r <= slot_mem[sc_r[IDX_W-1:0]];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sc_r        <= '0;
      dv_r        <= 1'b0;
      found_r     <= 1'b0;
      clash_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      sc_r        <= sc_nxt;
      dv_r        <= issue;
      found_r     <= found_nxt;
      clash_r     <= clash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= sc_r[IDX_W-1:0];
    pos_r <= pos_nxt;
    hit_r <= hit_nxt;
    if (cmd.load) begin
      act_r          <= req_action;
      req_r.id       <= req_id;
      req_r.ch_start <= req_start;
      req_r.ch_total <= req_total;
      req_r.ch_end   <= req_end;
    end
    if (cmd.commit) begin
      o_status_r <= res_status;
      o_index_r  <= idx_ext[INDEX_W-1:0];
      o_entry_r  <= res_entry;
      o_occ_r    <= occ_ext[OCC_W-1:0];
    end
  end

  assign out_tvalid    = out_valid_r;
  assign rsp_status    = o_status_r;
  assign rsp_index     = o_index_r;
  assign rsp_start     = o_entry_r.ch_start;
  assign rsp_channels  = o_entry_r.ch_total;
  assign rsp_end       = o_entry_r.ch_end;
  assign rsp_occupancy = o_occ_r;

endmodule

@@ tb/channel_range_fixture_table_test.sv @@
`timescale 1ns / 100ps

module channel_range_fixture_table_test;
  import crft_pkg::*;

  // Table size of the instance under test
  localparam int POOL         = DEF_POOL_DEPTH;
  localparam int LIMIT_CH     = DEF_CHANNEL_LIMIT;
  // The action code that the block treats as a no-op
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  // Worst case per request is a full scan plus a full shift
  localparam int TAIL_CYCLES  = 2 * POOL + 20;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int BURST_LEN    = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
    logic [CH_W-1:0]     ch_start;
    logic [CH_W-1:0]     ch_total;
    logic [CH_W-1:0]     ch_end;
    logic [OCC_W-1:0]    occupancy;
  } fixture_reply_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     fixture_id;
    logic [CH_W-1:0]     ch_start;
    logic [CH_W-1:0]     ch_total;
    logic [CH_W-1:0]     ch_end;
    logic                typed;   // golden reply written in the row itself
    fixture_reply_t      golden;
  } script_row_t;

  typedef enum int {BURST_FILL, BURST_CHURN, BURST_DRAIN} burst_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;

  channel_range_fixture_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Shadow copy of the fixture table, kept compact in insertion order
  logic [ID_W-1:0] fixture_ids    [POOL];
  logic [CH_W-1:0] fixture_starts [POOL];
  logic [CH_W-1:0] fixture_counts [POOL];
  logic [CH_W-1:0] fixture_ends   [POOL];
  int              fixture_fill;

  fixture_reply_t  pending_replies [$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int requests_sent;
  int replies_checked;
  int peak_fill;
  int status_hits [5];
  int grid_cursor;
  int unsigned cycle_count;

  script_row_t script_rows [$];

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort the run if the block stops answering
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Work out the reply for one request and advance the shadow table.
  function automatic fixture_reply_t predict_reply(input logic [ACTION_W-1:0] action,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [CH_W-1:0] ch_start,
                                                   input logic [CH_W-1:0] ch_total,
                                                   input logic [CH_W-1:0] ch_end);
    fixture_reply_t reply;
    int  hit;
    bit  clash;
    reply = '0;
    reply.status = ST_INVALID;
    hit = -1;
    for (int i = 0; i < fixture_fill; i++) begin
      if (hit < 0 && fixture_ids[i] == id) hit = i;
    end
    case (action)
      ACT_ADD: begin
        if (hit >= 0) begin
          reply.status = ST_DUPLICATE;
        end else if (int'(ch_end) > LIMIT_CH) begin
          reply.status = ST_INVALID;
        end else begin
          // The span runs start .. start+count-1; a zero count ends one below start
          clash = 1'b0;
          for (int i = 0; i < fixture_fill; i++) begin
            if (int'(ch_start) <= int'(fixture_ends[i]) &&
                int'(fixture_starts[i]) + 1 <= int'(ch_start) + int'(ch_total))
              clash = 1'b1;
          end
          if (clash) begin
            reply.status = ST_INVALID;
          end else if (fixture_fill >= POOL) begin
            reply.status = ST_FULL;
          end else begin
            fixture_ids[fixture_fill]    = id;
            fixture_starts[fixture_fill] = ch_start;
            fixture_counts[fixture_fill] = ch_total;
            fixture_ends[fixture_fill]   = ch_end;
            reply.index  = fixture_fill[INDEX_W-1:0];
            reply.status = ST_OK;
            fixture_fill++;
          end
        end
      end
      ACT_DEL: begin
        if (hit >= 0) begin
          for (int i = hit + 1; i < fixture_fill; i++) begin
            fixture_ids[i-1]    = fixture_ids[i];
            fixture_starts[i-1] = fixture_starts[i];
            fixture_counts[i-1] = fixture_counts[i];
            fixture_ends[i-1]   = fixture_ends[i];
          end
          fixture_fill--;
          reply.index  = hit[INDEX_W-1:0];
          reply.status = ST_OK;
        end else begin
          reply.status = ST_NOT_FOUND;
        end
      end
      ACT_GET: begin
        if (hit >= 0) begin
          reply.index    = hit[INDEX_W-1:0];
          reply.ch_start = fixture_starts[hit];
          reply.ch_total = fixture_counts[hit];
          reply.ch_end   = fixture_ends[hit];
          reply.status   = ST_OK;
        end else begin
          reply.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    reply.occupancy = fixture_fill[OCC_W-1:0];
    if (fixture_fill > peak_fill) peak_fill = fixture_fill;
    return reply;
  endfunction

  // Offer one request, hold it until taken, then queue its reply.
  task automatic send_request(input logic [ACTION_W-1:0] action,
                              input logic [ID_W-1:0] id,
                              input logic [CH_W-1:0] ch_start,
                              input logic [CH_W-1:0] ch_total,
                              input logic [CH_W-1:0] ch_end,
                              input bit typed = 1'b0,
                              input fixture_reply_t golden = '0);
    fixture_reply_t reply;
    // Drop valid for a random gap before offering the request
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {2'b00, ch_end, ch_total, ch_start, id};
    do @(posedge clk); while (!in_tready);
    reply = predict_reply(action, id, ch_start, ch_total, ch_end);
    if (typed) reply = golden;
    pending_replies.push_back(reply);
    status_hits[reply.status]++;
    requests_sent++;
  endtask

  // Hold the sender off until every outstanding request has been answered.
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  function automatic logic [ID_W-1:0] pick_id(input int live_pct);
    if (fixture_fill > 0 && $urandom_range(99) < live_pct)
      return fixture_ids[$urandom_range(fixture_fill - 1)];
    return ID_W'($urandom);
  endfunction

  // One random request, weighted by the kind of burst in progress.
  task automatic random_request(input burst_kind_t kind);
    int roll;
    int wf_add, noise_add, del_cut, get_cut;
    int grid_slot;
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     id;
    logic [CH_W-1:0]     ch_start, ch_total, ch_end;
    case (kind)
      BURST_FILL:  begin wf_add = 70; noise_add = 80; del_cut = 85; get_cut = 97; end
      BURST_CHURN: begin wf_add = 35; noise_add = 45; del_cut = 70; get_cut = 97; end
      default:     begin wf_add = 10; noise_add = 15; del_cut = 75; get_cut = 97; end
    endcase
    roll     = $urandom_range(99);
    id       = ID_W'($urandom);
    ch_start = CH_W'($urandom);
    ch_total = CH_W'($urandom);
    ch_end   = CH_W'($urandom);
    if (roll < wf_add) begin
      // Well-formed add: walk a grid of 16-channel cells so the table can fill
      action    = ACT_ADD;
      grid_slot = grid_cursor;
      grid_cursor = (grid_cursor + 1) % POOL;
      ch_start  = CH_W'(grid_slot * 16 + $urandom_range(3));
      ch_total  = CH_W'($urandom_range(1, 12));
      ch_end    = ch_start + ch_total - 1'b1;
    end else if (roll < noise_add) begin
      // Noisy add: raw fields, often a duplicate identifier
      action = ACT_ADD;
      id     = pick_id(50);
      if ($urandom_range(1)) ch_end = CH_W'($urandom_range(LIMIT_CH));
    end else if (roll < del_cut) begin
      action = ACT_DEL;
      id     = pick_id(85);
    end else if (roll < get_cut) begin
      action = ACT_GET;
      id     = pick_id(85);
    end else begin
      action = ACT_UNUSED;
    end
    send_request(action, id, ch_start, ch_total, ch_end);
  endtask

  function automatic script_row_t make_row(input logic [ACTION_W-1:0] action,
                                           input logic [ID_W-1:0] id,
                                           input int ch_start, input int ch_total,
                                           input int ch_end, input bit typed = 1'b0,
                                           input logic [STATUS_W-1:0] status = ST_OK,
                                           input int index = 0, input int occupancy = 0);
    script_row_t row;
    row = '0;
    row.action     = action;
    row.fixture_id = id;
    row.ch_start   = CH_W'(ch_start);
    row.ch_total   = CH_W'(ch_total);
    row.ch_end     = CH_W'(ch_end);
    row.typed      = typed;
    row.golden.status    = status;
    row.golden.index     = INDEX_W'(index);
    row.golden.occupancy = OCC_W'(occupancy);
    return row;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Receiver: check each accepted response against the oldest request, then
  // pick the ready level for the next cycle.
  always @(posedge clk) begin : response_check
    fixture_reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_replies.size() == 0) begin
          $error("response accepted with no request outstanding");
          error_count++;
        end else begin
          want = pending_replies.pop_front();
          check_field("status",         want.status,    out_tuser[2:0]);
          check_field("entry_index",    want.index,     out_tdata[4:0]);
          check_field("entry_start",    want.ch_start,  out_tdata[14:5]);
          check_field("entry_channels", want.ch_total,  out_tdata[24:15]);
          check_field("entry_end",      want.ch_end,    out_tdata[34:25]);
          check_field("occupancy",      want.occupancy, out_tdata[40:35]);
          replies_checked++;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    burst_kind_t kind;
    script_row_t row;
    fixture_fill = 0;
    error_count = 0;
    requests_sent = 0;
    replies_checked = 0;
    peak_fill = 0;
    grid_cursor = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    send_idle_pct = 30;
    recv_idle_pct = 76;

    // Directed script. Rows with a golden reply typed in hold the answers that
    // follow straight from an empty table; the rest go to the predictor.
    script_rows.push_back(make_row(ACT_GET, 16'h1234, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0));
    script_rows.push_back(make_row(ACT_DEL, 16'hFFFF, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0));
    // Unused action with every data bit set: ignored, reported as invalid
    script_rows.push_back(make_row(ACT_UNUSED, 16'hFFFF, 1023, 1023, 1023, 1,
                                   ST_INVALID, 0, 0));
    script_rows.push_back(make_row(ACT_ADD, 16'h0000, 0, 1, 0, 1, ST_OK, 0, 1));
    script_rows.push_back(make_row(ACT_ADD, 16'h0000, 0, 1, 0, 1, ST_DUPLICATE, 0, 1));
    // Duplicate wins over a last channel above the limit
    script_rows.push_back(make_row(ACT_ADD, 16'h0000, 900, 5, 1023, 1, ST_DUPLICATE, 0, 1));
    script_rows.push_back(make_row(ACT_ADD, 16'h0001, 100, 10, 513, 1, ST_INVALID, 0, 1));
    // Last channel exactly at the limit is allowed
    script_rows.push_back(make_row(ACT_ADD, 16'hFFFF, 512, 1, 512, 1, ST_OK, 1, 2));
    // Zero channel count: span ends just below the start
    script_rows.push_back(make_row(ACT_ADD, 16'h0002, 0, 0, 0));
    // Overlap with the fixture at channel 512
    script_rows.push_back(make_row(ACT_ADD, 16'h0003, 500, 20, 511));
    script_rows.push_back(make_row(ACT_ADD, 16'h0004, 1023, 1023, 512));
    script_rows.push_back(make_row(ACT_GET, 16'hFFFF, 0, 0, 0));
    script_rows.push_back(make_row(ACT_GET, 16'h0000, 0, 0, 0));
    script_rows.push_back(make_row(ACT_GET, 16'h0004, 0, 0, 0));
    script_rows.push_back(make_row(ACT_DEL, 16'h0000, 0, 0, 0));
    script_rows.push_back(make_row(ACT_GET, 16'hFFFF, 0, 0, 0));
    script_rows.push_back(make_row(ACT_GET, 16'h0000, 0, 0, 0));
    script_rows.push_back(make_row(ACT_DEL, 16'hFFFF, 0, 0, 0));
    script_rows.push_back(make_row(ACT_ADD, 16'hAAAA, 0, 512, 511));
    script_rows.push_back(make_row(ACT_DEL, 16'h0002, 0, 0, 0));
    script_rows.push_back(make_row(ACT_DEL, 16'h0004, 0, 0, 0));
    script_rows.push_back(make_row(ACT_ADD, 16'h5555, 0, 512, 511));
    script_rows.push_back(make_row(ACT_GET, 16'h5555, 0, 0, 0));
    script_rows.push_back(make_row(ACT_UNUSED, 16'h0000, 0, 0, 0));
    script_rows.push_back(make_row(ACT_DEL, 16'h5555, 0, 0, 0));

    // Hold reset low at the start, then release it once
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script_rows[i]) begin
      row = script_rows[i];
      send_request(row.action, row.fixture_id, row.ch_start, row.ch_total, row.ch_end,
                   row.typed, row.golden);
    end

    // Random phases: slow sender / slow receiver, then the reverse, then flat out
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 30; recv_idle_pct = 76; end
        1:       begin send_idle_pct = 76; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      // Let the table settle with nothing in flight before each phase
      drain_replies();
      kind = BURST_FILL;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Pick a burst kind at random every BURST_LEN requests
        if (n % BURST_LEN == 0) begin
          case ($urandom_range(2))
            0:       kind = BURST_FILL;
            1:       kind = BURST_CHURN;
            default: kind = BURST_DRAIN;
          endcase
        end
        random_request(kind);
      end
    end

    // Drop valid, wait for the last replies, then watch for strays
    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) error_count++;

    $display("Covered %0d requests and %0d checked responses, peak occupancy %0d of %0d.",
             requests_sent, replies_checked, peak_fill, POOL);
    $display("Status mix: ok %0d, duplicate %0d, invalid %0d, not found %0d, full %0d.",
             status_hits[ST_OK], status_hits[ST_DUPLICATE], status_hits[ST_INVALID],
             status_hits[ST_NOT_FOUND], status_hits[ST_FULL]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
